[hw/rtl/sthd_pkg.sv]
// ----------------------------------------------------------------------------
// sthd_pkg: shared definitions for the scheduled thermostat heat decision
// Field widths, register indexes, operating modes and the window test.
// ----------------------------------------------------------------------------
package sthd_pkg;

	localparam int MIN_W      = 11;
	localparam int DAY_W      = 3;
	localparam int TEMP_W     = 12;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 46;
	localparam int PERIOD_W   = MIN_W + TEMP_W;
	localparam int WATER_W    = 2 * MIN_W + TEMP_W + 1;

	localparam int REG_WEEKDAY_SLOTS = 4;
	localparam int REG_WEEKEND_SLOTS = 2;

	localparam int DEF_WEEKDAY_PERIODS = 4;
	localparam int DEF_WEEKEND_PERIODS = 2;

	localparam logic [DAY_W-1:0] DAY_SATURDAY = 3'd6;
	localparam logic [DAY_W-1:0] DAY_SUNDAY   = 3'd7;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF     = 2'd0,
		MODE_WATER   = 2'd1,
		MODE_HEATING = 2'd2,
		MODE_MANUAL  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_MANUAL_SP = 3'd1,
		REG_WATER     = 3'd2,
		REG_WKDAY_0   = 3'd3,
		REG_WKDAY_1   = 3'd4,
		REG_WKDAY_2   = 3'd5,
		REG_WKDAY_3   = 3'd6,
		REG_WKEND     = 3'd7
	} reg_idx_t;

	// Window [start, end); start > end wraps past midnight and includes end,
	// start == end never matches.
	function automatic logic in_window(
		input logic [MIN_W-1:0] now,
		input logic [MIN_W-1:0] start,
		input logic [MIN_W-1:0] stop
	);
		logic hit;
		hit = 1'b0;
		if (start < stop) begin
			hit = (now >= start) && (now < stop);
		end else if (start > stop) begin
			hit = !((now > stop) && (now < start));
		end
		return hit;
	endfunction

endpackage

[hw/rtl/sthd_if.sv]
// ----------------------------------------------------------------------------
// sthd_if: request channels of the heat decision unit
// Sample input, decision output and configuration write channels.
// ----------------------------------------------------------------------------
interface sthd_in_if
	import sthd_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [MIN_W-1:0]         minute_of_day;
	logic [DAY_W-1:0]         day_of_week;
	logic signed [TEMP_W-1:0] boiler_temp;
	logic signed [TEMP_W-1:0] room_temp;

	modport source (output valid, minute_of_day, day_of_week, boiler_temp, room_temp,
		input ready);
	modport sink (input valid, minute_of_day, day_of_week, boiler_temp, room_temp,
		output ready);
endinterface

interface sthd_out_if
	import sthd_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     heat_on;
	logic signed [TEMP_W-1:0] shown_setpoint;
	logic                     setpoint_valid;

	modport source (output valid, heat_on, shown_setpoint, setpoint_valid, input ready);
	modport sink (input valid, heat_on, shown_setpoint, setpoint_valid, output ready);
endinterface

interface sthd_cfg_if
	import sthd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/scheduled_thermostat_heat_decision_unit.sv]
// ----------------------------------------------------------------------------
// scheduled_thermostat_heat_decision_unit: boiler on/off decision per sample
// Three-stage pipeline deciding heat from mode, schedule and temperatures.
// ----------------------------------------------------------------------------
// One request in, one decision out, one request per cycle sustained while the
// output is taken. Stage 1 runs every window and temperature compare for both
// the weekday and the weekend schedule, stage 2 walks the period matches in
// order, stage 3 picks the schedule and the mode and holds the result. The
// stages advance together: the input is ready whenever the output register is
// empty or being taken, so a stalled output backs up the whole pipe without
// loss. Configuration writes are always ready and should only be issued with
// the pipe empty. Schedule periods run from their own start to the next
// period's start, the last one wrapping to the first.
module scheduled_thermostat_heat_decision_unit
	import sthd_pkg::*;
#(
	parameter int WEEKDAY_PERIODS = DEF_WEEKDAY_PERIODS,
	parameter int WEEKEND_PERIODS = DEF_WEEKEND_PERIODS
) (
	input logic        clk,
	input logic        arst_n,
	sthd_in_if.sink    in_ch,
	sthd_out_if.source out_ch,
	sthd_cfg_if.sink   cfg_ch
);

	// ---------------- configuration registers ----------------
	mode_t                    mode_q;
	logic signed [TEMP_W-1:0] manual_sp_q;
	logic [WATER_W-1:0]       water_q;
	logic [PERIOD_W-1:0]      wkday_q [REG_WEEKDAY_SLOTS];
	logic [2*PERIOD_W-1:0]    wkend_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			manual_sp_q <= '0;
			water_q     <= '0;
			wkend_q     <= '0;
			for (int i = 0; i < REG_WEEKDAY_SLOTS; i++) begin
				wkday_q[i] <= '0;
			end
		end else if (cfg_ch.valid) begin
			case (reg_idx_t'(cfg_ch.index))
				REG_MODE:      mode_q      <= mode_t'(cfg_ch.data[MODE_W-1:0]);
				REG_MANUAL_SP: manual_sp_q <= $signed(cfg_ch.data[TEMP_W-1:0]);
				REG_WATER:     water_q     <= cfg_ch.data[WATER_W-1:0];
				REG_WKDAY_0:   wkday_q[0]  <= cfg_ch.data[PERIOD_W-1:0];
				REG_WKDAY_1:   wkday_q[1]  <= cfg_ch.data[PERIOD_W-1:0];
				REG_WKDAY_2:   wkday_q[2]  <= cfg_ch.data[PERIOD_W-1:0];
				REG_WKDAY_3:   wkday_q[3]  <= cfg_ch.data[PERIOD_W-1:0];
				REG_WKEND:     wkend_q     <= cfg_ch.data[2*PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack water settings
	logic [MIN_W-1:0]         water_start;
	logic [MIN_W-1:0]         water_end;
	logic signed [TEMP_W-1:0] water_target;
	logic                     water_watch;

	assign water_start  = water_q[MIN_W-1:0];
	assign water_end    = water_q[2*MIN_W-1:MIN_W];
	assign water_target = $signed(water_q[2*MIN_W+TEMP_W-1:2*MIN_W]);
	assign water_watch  = water_q[WATER_W-1];

	// Unpack schedule periods; weekend slots beyond the register read as zero
	logic [MIN_W-1:0]         wd_start  [WEEKDAY_PERIODS];
	logic signed [TEMP_W-1:0] wd_target [WEEKDAY_PERIODS];
	logic [MIN_W-1:0]         we_start  [WEEKEND_PERIODS];
	logic signed [TEMP_W-1:0] we_target [WEEKEND_PERIODS];

	for (genvar g = 0; g < WEEKDAY_PERIODS; g++) begin : g_wd_unpack
		assign wd_start[g]  = wkday_q[g][MIN_W-1:0];
		assign wd_target[g] = $signed(wkday_q[g][PERIOD_W-1:MIN_W]);
	end

	for (genvar g = 0; g < WEEKEND_PERIODS; g++) begin : g_we_unpack
		if (g < REG_WEEKEND_SLOTS) begin : g_reg
			assign we_start[g]  = wkend_q[g*PERIOD_W +: MIN_W];
			assign we_target[g] = $signed(wkend_q[g*PERIOD_W+MIN_W +: TEMP_W]);
		end else begin : g_zero
			assign we_start[g]  = '0;
			assign we_target[g] = '0;
		end
	end

	// ---------------- pipeline control ----------------
	logic v_s1, v_s2, v_s3;
	logic adv;

	assign adv          = !v_s3 || out_ch.ready;
	assign in_ch.ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: compares ----------------
	logic [WEEKDAY_PERIODS-1:0] wd_match_s1, wd_hot_s1;
	logic [WEEKEND_PERIODS-1:0] we_match_s1, we_hot_s1;
	logic                       weekend_s1;
	logic                       water_heat_s1;
	logic                       manual_heat_s1;

	logic [WEEKDAY_PERIODS-1:0] wd_match_c, wd_hot_c;
	logic [WEEKEND_PERIODS-1:0] we_match_c, we_hot_c;

	for (genvar g = 0; g < WEEKDAY_PERIODS; g++) begin : g_wd_cmp
		localparam int NXT = (g + 1) % WEEKDAY_PERIODS;
		assign wd_match_c[g] = in_window(in_ch.minute_of_day, wd_start[g], wd_start[NXT]);
		assign wd_hot_c[g]   = in_ch.boiler_temp < wd_target[g];
	end

	for (genvar g = 0; g < WEEKEND_PERIODS; g++) begin : g_we_cmp
		localparam int NXT = (g + 1) % WEEKEND_PERIODS;
		assign we_match_c[g] = in_window(in_ch.minute_of_day, we_start[g], we_start[NXT]);
		assign we_hot_c[g]   = in_ch.boiler_temp < we_target[g];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wd_match_s1    <= wd_match_c;
			wd_hot_s1      <= wd_hot_c;
			we_match_s1    <= we_match_c;
			we_hot_s1      <= we_hot_c;
			weekend_s1     <= (in_ch.day_of_week == DAY_SATURDAY) ||
				(in_ch.day_of_week == DAY_SUNDAY);
			water_heat_s1  <= in_window(in_ch.minute_of_day, water_start, water_end) &&
				(!water_watch || (in_ch.boiler_temp < water_target));
			manual_heat_s1 <= in_ch.room_temp < manual_sp_q;
		end
	end

	// ---------------- stage 2: period walk ----------------
	// First matched period that is above the boiler wins; otherwise the last
	// matched period is shown without heating.
	logic                     wd_heat_c, wd_any_c;
	logic signed [TEMP_W-1:0] wd_shown_c;
	logic                     we_heat_c, we_any_c;
	logic signed [TEMP_W-1:0] we_shown_c;

	always_comb begin
		wd_heat_c  = 1'b0;
		wd_any_c   = 1'b0;
		wd_shown_c = '0;
		for (int i = 0; i < WEEKDAY_PERIODS; i++) begin
			if (!wd_heat_c && wd_match_s1[i]) begin
				wd_any_c   = 1'b1;
				wd_shown_c = wd_target[i];
				wd_heat_c  = wd_hot_s1[i];
			end
		end
	end

	always_comb begin
		we_heat_c  = 1'b0;
		we_any_c   = 1'b0;
		we_shown_c = '0;
		for (int i = 0; i < WEEKEND_PERIODS; i++) begin
			if (!we_heat_c && we_match_s1[i]) begin
				we_any_c   = 1'b1;
				we_shown_c = we_target[i];
				we_heat_c  = we_hot_s1[i];
			end
		end
	end

	logic                     wd_heat_s2, wd_any_s2;
	logic signed [TEMP_W-1:0] wd_shown_s2;
	logic                     we_heat_s2, we_any_s2;
	logic signed [TEMP_W-1:0] we_shown_s2;
	logic                     weekend_s2;
	logic                     water_heat_s2;
	logic                     manual_heat_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			wd_heat_s2     <= wd_heat_c;
			wd_any_s2      <= wd_any_c;
			wd_shown_s2    <= wd_shown_c;
			we_heat_s2     <= we_heat_c;
			we_any_s2      <= we_any_c;
			we_shown_s2    <= we_shown_c;
			weekend_s2     <= weekend_s1;
			water_heat_s2  <= water_heat_s1;
			manual_heat_s2 <= manual_heat_s1;
		end
	end

	// ---------------- stage 3: schedule and mode select ----------------
	logic                     heat_c, sp_valid_c;
	logic signed [TEMP_W-1:0] shown_c;

	always_comb begin
		heat_c     = 1'b0;
		sp_valid_c = 1'b0;
		shown_c    = '0;
		case (mode_q)
			MODE_OFF:    heat_c = 1'b0;
			MODE_WATER:  heat_c = water_heat_s2;
			MODE_HEATING: begin
				heat_c     = weekend_s2 ? we_heat_s2  : wd_heat_s2;
				sp_valid_c = weekend_s2 ? we_any_s2   : wd_any_s2;
				shown_c    = weekend_s2 ? we_shown_s2 : wd_shown_s2;
			end
			MODE_MANUAL: heat_c = manual_heat_s2;
			default:     heat_c = 1'b0;
		endcase
	end

	logic                     heat_s3, sp_valid_s3;
	logic signed [TEMP_W-1:0] shown_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			heat_s3     <= heat_c;
			sp_valid_s3 <= sp_valid_c;
			shown_s3    <= shown_c;
		end
	end

	assign out_ch.valid          = v_s3;
	assign out_ch.heat_on        = heat_s3;
	assign out_ch.shown_setpoint = shown_s3;
	assign out_ch.setpoint_valid = sp_valid_s3;

endmodule

[hw/rtl/sthd_checker.sv]
// ----------------------------------------------------------------------------
// sthd_checker: port-level checks for the heat decision unit
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module sthd_checker
	import sthd_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     heat_on,
	input logic signed [TEMP_W-1:0] shown_setpoint,
	input logic                     setpoint_valid,
	input logic                     cfg_valid,
	input logic                     cfg_ready
);

	// A held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({heat_on, shown_setpoint, setpoint_valid}))
		else $error("result changed while stalled");

	// No matched period means nothing to show
	a_shown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !setpoint_valid |-> shown_setpoint == '0)
		else $error("setpoint shown without a match");

	// Pipe only back-pressures when the output register is full and stalled
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with room in the pipe");

	// Config writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind scheduled_thermostat_heat_decision_unit sthd_checker u_sthd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.heat_on        (out_ch.heat_on),
	.shown_setpoint (out_ch.shown_setpoint),
	.setpoint_valid (out_ch.setpoint_valid),
	.cfg_valid      (cfg_ch.valid),
	.cfg_ready      (cfg_ch.ready)
);

[tb/scheduled_thermostat_heat_decision_unit_tb.sv]
// ----------------------------------------------------------------------------
// scheduled_thermostat_heat_decision_unit_tb: self-checking bench
// Drives samples and register writes into the heat decision unit and checks
// every decision against an in-bench model of the mode, window and period
// logic. A directed part is followed by randomized schedules and samples run
// under three throttling profiles, including one long output stall.
// ----------------------------------------------------------------------------
module scheduled_thermostat_heat_decision_unit_tb;
	import sthd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WEEKDAY_SLOTS = DEF_WEEKDAY_PERIODS;
	localparam int WEEKEND_SLOTS = DEF_WEEKEND_PERIODS;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 140;
	localparam int HOLD_CYCLES   = 300;
	// far beyond the slowest legal run of the bench
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct packed {
		logic [MIN_W-1:0]         minute;
		logic [DAY_W-1:0]         day;
		logic signed [TEMP_W-1:0] boiler;
		logic signed [TEMP_W-1:0] room;
	} sample_t;

	typedef struct packed {
		logic                     heat;
		logic signed [TEMP_W-1:0] shown;
		logic                     shown_ok;
	} decision_t;

	// Mirror of the register file plus the decisions still owed by the block.
	class heat_decision_board;
		logic [MODE_W-1:0]   mode_reg;
		logic [TEMP_W-1:0]   manual_sp;
		logic [WATER_W-1:0]  water;
		logic [PERIOD_W-1:0] wkday [REG_WEEKDAY_SLOTS];
		logic [CFG_DATA_W-1:0] wkend;
		decision_t owed_decisions [$];
		int mismatches;

		function new();
			mode_reg = '0;
			manual_sp = '0;
			water = '0;
			foreach (wkday[i]) wkday[i] = '0;
			wkend = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (reg_idx_t'(idx))
				REG_MODE:      mode_reg = value[MODE_W-1:0];
				REG_MANUAL_SP: manual_sp = value[TEMP_W-1:0];
				REG_WATER:     water = value[WATER_W-1:0];
				REG_WKDAY_0:   wkday[0] = value[PERIOD_W-1:0];
				REG_WKDAY_1:   wkday[1] = value[PERIOD_W-1:0];
				REG_WKDAY_2:   wkday[2] = value[PERIOD_W-1:0];
				REG_WKDAY_3:   wkday[3] = value[PERIOD_W-1:0];
				REG_WKEND:     wkend = value;
				default: ;
			endcase
		endfunction

		// plain window, wrapped window (end included), empty when start == end
		function bit spans(logic [MIN_W-1:0] now, logic [MIN_W-1:0] start,
				logic [MIN_W-1:0] stop);
			if (start < stop) begin
				return (now >= start) && (now < stop);
			end else if (start > stop) begin
				return !((now > stop) && (now < start));
			end
			return 1'b0;
		endfunction

		function logic [PERIOD_W-1:0] schedule_word(bit weekend, int slot);
			if (weekend) begin
				if (slot == 0) return wkend[PERIOD_W-1:0];
				if (slot == 1) return wkend[2*PERIOD_W-1:PERIOD_W];
				return '0;
			end
			if (slot < REG_WEEKDAY_SLOTS) return wkday[slot];
			return '0;
		endfunction

		function decision_t decide_heat(sample_t s);
			decision_t d;
			bit weekend;
			int n;
			logic [PERIOD_W-1:0] cur, nxt;
			logic signed [TEMP_W-1:0] target, boiler, room, sp;
			d = '0;
			boiler = s.boiler;
			room = s.room;
			sp = manual_sp;
			case (mode_t'(mode_reg))
				MODE_WATER: begin
					target = water[33:22];
					if (spans(s.minute, water[10:0], water[21:11]) &&
							(!water[34] || boiler < target))
						d.heat = 1'b1;
				end
				MODE_HEATING: begin
					weekend = (s.day == DAY_SATURDAY) || (s.day == DAY_SUNDAY);
					n = weekend ? WEEKEND_SLOTS : WEEKDAY_SLOTS;
					for (int i = 0; i < n; i++) begin
						cur = schedule_word(weekend, i);
						nxt = schedule_word(weekend, (i + 1) % n);
						target = cur[22:11];
						if (spans(s.minute, cur[10:0], nxt[10:0])) begin
							d.shown = target;
							d.shown_ok = 1'b1;
							if (boiler < target) begin
								d.heat = 1'b1;
								break;
							end
						end
					end
				end
				MODE_MANUAL: begin
					if (room < sp) d.heat = 1'b1;
				end
				default: ;
			endcase
			return d;
		endfunction

		function void note_sample(sample_t s);
			owed_decisions.push_back(decide_heat(s));
		endfunction

		function void check_decision(decision_t got);
			decision_t want;
			if (owed_decisions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected decision: heat %0b setpoint %0d valid %0b",
						got.heat, got.shown, got.shown_ok);
				return;
			end
			want = owed_decisions.pop_front();
			if (got.heat !== want.heat || got.shown !== want.shown ||
					got.shown_ok !== want.shown_ok) begin
				mismatches++;
				if (mismatches <= 10)
					$display("decision mismatch: heat %0b/%0b setpoint %0d/%0d valid %0b/%0b",
						want.heat, got.heat, want.shown, got.shown,
						want.shown_ok, got.shown_ok);
			end
		endfunction

		function int pending();
			return owed_decisions.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sthd_in_if  in_ch ();
	sthd_out_if out_ch ();
	sthd_cfg_if cfg_ch ();

	scheduled_thermostat_heat_decision_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	heat_decision_board board;

	// throttling, in percent of cycles idle
	int send_idle;
	int recv_idle;
	// long output stall, armed once by the stimulus, timed by the receiver
	bit hold_go;
	bit hold_done;
	int hold_left;
	int cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("scheduled_thermostat_heat_decision_unit_tb: errors");
			$finish;
		end
	end

	// Receiver: random back-pressure, or a solid stall once hold_go is seen.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Monitor: values read here are the ones present before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				board.note_sample('{in_ch.minute_of_day, in_ch.day_of_week,
					in_ch.boiler_temp, in_ch.room_temp});
			if (out_ch.valid && out_ch.ready)
				board.check_decision('{out_ch.heat_on, out_ch.shown_setpoint,
					out_ch.setpoint_valid});
			if (cfg_ch.valid && cfg_ch.ready)
				board.set_reg(cfg_ch.index, cfg_ch.data);
		end
	end

	// Offers one sample request; valid is left high for a back-to-back next one.
	task automatic send_sample(input int minute, input int day, input int boiler,
			input int room);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.minute_of_day <= MIN_W'(minute);
		in_ch.day_of_week <= DAY_W'(day);
		in_ch.boiler_temp <= TEMP_W'(boiler);
		in_ch.room_temp <= TEMP_W'(room);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// Caller lowers cfg valid after the last write of a burst.
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic program_all(input logic [CFG_DATA_W-1:0] mode, sp, water,
			wk0, wk1, wk2, wk3, wkend);
		write_reg(REG_MODE, mode);
		write_reg(REG_MANUAL_SP, sp);
		write_reg(REG_WATER, water);
		write_reg(REG_WKDAY_0, wk0);
		write_reg(REG_WKDAY_1, wk1);
		write_reg(REG_WKDAY_2, wk2);
		write_reg(REG_WKDAY_3, wk3);
		write_reg(REG_WKEND, wkend);
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits for the pipe to empty, plus a margin over its three-stage latency.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pack_period(int start, int tgt);
		return {23'd0, TEMP_W'(tgt), MIN_W'(start)};
	endfunction

	// both weekend periods in one register word, period 0 in the low half
	function automatic logic [CFG_DATA_W-1:0] pack_weekend(int start0, int tgt0,
			int start1, int tgt1);
		return {TEMP_W'(tgt1), MIN_W'(start1), TEMP_W'(tgt0), MIN_W'(start0)};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pack_water(int start, int stop, int tgt,
			bit watch);
		return {11'd0, watch, TEMP_W'(tgt), MIN_W'(stop), MIN_W'(start)};
	endfunction

	// mostly real minutes of the day, now and then anything 11 bits hold
	function automatic int rand_minute();
		if ($urandom_range(7) == 0) return $urandom_range(0, 2047);
		return $urandom_range(0, 1439);
	endfunction

	// clustered near zero so targets and readings cross often
	function automatic int rand_temp();
		if ($urandom_range(3) == 0) return int'($urandom_range(0, 4095)) - 2048;
		return int'($urandom_range(0, 600)) - 300;
	endfunction

	// sets bits above the register width at random; the block must drop them
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'({$urandom, $urandom});
		if ($urandom_range(1) == 0) return v;
		return v | (junk << w);
	endfunction

	task automatic run_directed();
		// reset values: mode off, nothing heats
		send_sample(0, 0, -2048, -2048);
		send_sample(2047, 7, 2047, 2047);
		drain();

		// manual at both setpoint extremes
		program_all(46'(MODE_MANUAL), 46'(12'sd2047), 0, 0, 0, 0, 0, 0);
		send_sample(100, 1, 0, 2046);
		send_sample(100, 1, 0, 2047);
		drain();
		write_reg(REG_MANUAL_SP, 46'(-12'sd2048));
		cfg_ch.valid <= 1'b0;
		send_sample(0, 2, 0, -2048);
		drain();

		// water, window wrapping past midnight, watching the boiler
		program_all(46'(MODE_WATER), 0, pack_water(1380, 300, 500, 1'b1), 0, 0, 0, 0, 0);
		send_sample(300, 1, 499, 0);
		send_sample(301, 1, 0, 0);
		send_sample(1380, 1, 0, 0);
		send_sample(1379, 1, 0, 0);
		send_sample(0, 1, 500, 0);
		drain();
		// unwatched plain window, start equals end, minutes past the day
		write_reg(REG_WATER, pack_water(100, 200, -2048, 1'b0));
		cfg_ch.valid <= 1'b0;
		send_sample(100, 3, 2047, 0);
		send_sample(200, 3, 0, 0);
		drain();
		write_reg(REG_WATER, pack_water(600, 600, 2047, 1'b0));
		cfg_ch.valid <= 1'b0;
		send_sample(600, 3, 0, 0);
		drain();
		write_reg(REG_WATER, pack_water(1500, 2047, 0, 1'b0));
		cfg_ch.valid <= 1'b0;
		send_sample(2000, 4, 0, 0);
		drain();

		// ordinary daily schedule, weekday and weekend
		program_all(46'(MODE_HEATING), 0, 0,
			pack_period(360, 200), pack_period(480, 150),
			pack_period(1020, 210), pack_period(1320, 100),
			pack_weekend(420, 220, 1380, 180));
		send_sample(400, 1, 100, 0);   // first period heats
		send_sample(400, 3, 250, 0);   // matched but warm enough
		send_sample(0, 5, 50, 0);      // last period wraps to the first
		send_sample(360, 6, 0, 0);     // weekend wrapped period
		send_sample(1380, 7, 0, 0);    // start of the wrapped period itself
		send_sample(500, 0, 2047, 0);  // day code zero counts as a weekday
		drain();

		// overlapping windows: the walk goes on past a matched period that
		// does not heat and stops at the first one that does
		program_all(46'(MODE_HEATING), 0, 0,
			pack_period(100, 100), pack_period(1000, -50),
			pack_period(50, 300), pack_period(1200, 0), 0);
		send_sample(500, 2, 200, 0);
		send_sample(500, 2, 400, 0);
		send_sample(500, 2, 50, 0);
		drain();
		// every start equal: no period matches
		program_all(46'(MODE_HEATING), 0, 0,
			pack_period(700, 500), pack_period(700, 500),
			pack_period(700, 500), pack_period(700, 500),
			pack_weekend(700, 500, 700, 500));
		send_sample(700, 1, -2048, 0);
		send_sample(700, 6, -2048, 0);
		drain();
	endtask

	task automatic run_random_phase(input int phase);
		mode_t mode;
		int starts [$];
		logic [CFG_DATA_W-1:0] wk [REG_WEEKDAY_SLOTS];
		logic [CFG_DATA_W-1:0] we0, we1, water;
		case (phase % 6)
			0, 4: mode = MODE_HEATING;
			1: mode = MODE_WATER;
			3: mode = MODE_MANUAL;
			5: mode = (phase > 6) ? MODE_HEATING : MODE_OFF;
			default: mode = MODE_HEATING;
		endcase

		if (phase == 2) begin
			// every register bit set
			program_all('1, '1, '1, '1, '1, '1, '1, '1);
		end else if (phase == 6) begin
			// heating over an all-zero schedule
			program_all(46'(MODE_HEATING), 0, 0, 0, 0, 0, 0, 0);
		end else begin
			starts.delete();
			for (int i = 0; i < REG_WEEKDAY_SLOTS; i++) starts.push_back(rand_minute());
			// real schedules run in order; unordered ones make overlaps
			if ($urandom_range(2) != 0) starts.sort();
			if ($urandom_range(5) == 0) starts[1] = starts[0];
			for (int i = 0; i < REG_WEEKDAY_SLOTS; i++)
				wk[i] = with_junk(pack_period(starts[i], rand_temp()), PERIOD_W);
			we0 = pack_period(rand_minute(), rand_temp());
			we1 = pack_period(rand_minute(), rand_temp());
			water = pack_water(rand_minute(), rand_minute(), rand_temp(),
				1'($urandom_range(1)));
			program_all(with_junk(46'(mode), MODE_W),
				with_junk(46'(TEMP_W'(rand_temp())), TEMP_W),
				with_junk(water, WATER_W), wk[0], wk[1], wk[2], wk[3],
				{we1[22:0], we0[22:0]});
		end

		if (phase == 1) hold_go = 1'b1;
		for (int n = 0; n < PHASE_ITEMS; n++)
			send_sample(rand_minute(), $urandom_range(0, 7), rand_temp(), rand_temp());
		drain();
	endtask

	initial begin
		board = new();
		cycles = 0;
		send_idle = 20;
		recv_idle = 59;
		hold_go = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.minute_of_day = '0;
		in_ch.day_of_week = '0;
		in_ch.boiler_temp = '0;
		in_ch.room_temp = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			// sender light / receiver heavy, then swapped, then full rate
			if (p < PHASES / 3) begin
				send_idle = 20;
				recv_idle = 59;
			end else if (p < 2 * PHASES / 3) begin
				send_idle = 59;
				recv_idle = 20;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			run_random_phase(p);
		end

		drain();
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("scheduled_thermostat_heat_decision_unit_tb: clean");
		end else begin
			$display("scheduled_thermostat_heat_decision_unit_tb: errors");
		end
		$finish;
	end

endmodule
